FILE: design/connect_header_parser_defines.svh
// assertion macros for the connect header parser
`ifndef CONNECT_HEADER_PARSER_DEFINES_SVH
`define CONNECT_HEADER_PARSER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CHP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define CHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/chp_pkg.sv
package chp_pkg;

  // default line length limit and host name limit
  localparam int MAX_LINE_DEF = 512;
  localparam int MAX_HOST     = 149;

  // port encodings
  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;
  localparam logic [16:0] PORT_NONE        = 17'h10000;
  localparam logic [16:0] PORT_UNSEEN      = 17'h1FFFF;
  localparam logic [16:0] PORT_MAX         = 17'h0FFFF;

  // characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_UC_H  = 8'h48;

  // result kinds
  localparam logic RK_HOST_BYTE = 1'b0;
  localparam logic RK_SUMMARY   = 1'b1;

  typedef enum logic [1:0] {
    LC_UNDECIDED = 2'd0,
    LC_CONNECT   = 2'd1,
    LC_HOST      = 2'd2,
    LC_OTHER     = 2'd3
  } line_class_t;

  typedef enum logic [1:0] {
    HS_NONE  = 2'd0,
    HS_EMIT  = 2'd1,
    HS_DONE  = 2'd2,
    HS_TRUNC = 2'd3
  } host_state_t;

  typedef enum logic [1:0] {
    CS_WAIT   = 2'd0,
    CS_DIGITS = 2'd1,
    CS_DONE   = 2'd2
  } colon_state_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  host_byte;
    logic        is_connect;
    logic        host_found;
    logic [15:0] server_port;
    logic [7:0]  host_length;
    logic        host_truncated;
  } result_t;

  typedef struct packed {
    colon_state_t colon;
    logic [16:0]  port;
  } port_upd_t;

  // "CONNECT " spelled by position
  function automatic logic [7:0] connect_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h43;
      3'd1: c = 8'h4F;
      3'd2: c = 8'h4E;
      3'd3: c = 8'h4E;
      3'd4: c = 8'h45;
      3'd5: c = 8'h43;
      3'd6: c = 8'h54;
      3'd7: c = 8'h20;
    endcase
    return c;
  endfunction

  // "Host: " spelled by position
  function automatic logic [7:0] host_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h48;
      3'd1: c = 8'h6F;
      3'd2: c = 8'h73;
      3'd3: c = 8'h74;
      3'd4: c = 8'h3A;
      3'd5: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // one byte of port text: colon, then leading decimal digits, saturating
  function automatic port_upd_t port_step(input colon_state_t colon,
                                          input logic [16:0] port,
                                          input logic [7:0] b);
    port_upd_t r;
    logic [19:0] v;
    r.colon = colon;
    r.port  = port;
    v       = '0;
    unique case (colon)
      CS_WAIT: begin
        if (b == CH_COLON) begin
          r.colon = CS_DIGITS;
          r.port  = '0;
        end
      end
      CS_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          v = 20'(port[15:0]) * 20'd10 + 20'(8'(b - CH_ZERO));
          r.port = (v > 20'(PORT_MAX)) ? PORT_MAX : v[16:0];
        end else begin
          r.colon = CS_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

FILE: design/chp_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface chp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/connect_header_parser.sv
// Parses an HTTP request header arriving one byte per transaction on header
// and returns, on result, one transaction per host name byte of the first
// "Host: " line and one summary transaction when CR LF CR LF ends the header.
// The summary tells whether the header began with CONNECT, whether a Host
// line was found, the chosen port (CONNECT line port, else Host line port,
// else default_port, saturated at 65535), the host name length and whether
// the name was cut at the host limit; state then clears for the next request.
// One byte is accepted every cycle while header.ready is high; it updates
// state registers and any result enters one output register, on result the
// cycle after. header.ready is low only while that register holds a result
// not yet taken by result.ready. The user must write default_port through
// cfg_wr_en / cfg_wr_data only while no request is in flight (unenforced).
`include "connect_header_parser_defines.svh"

module connect_header_parser #(
  parameter int MAX_LINE = chp_pkg::MAX_LINE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  chp_stream_if.sink   header,
  chp_stream_if.source result
);
  import chp_pkg::*;

  localparam int LW = $clog2(MAX_LINE);

  // request state
  logic [15:0]   default_port;
  logic [LW-1:0] line_offset, line_offset_next;
  line_class_t   line_class, line_class_next;
  logic [1:0]    end_match_count, end_match_count_next;
  logic          prefix_ok, prefix_ok_next;
  logic          connect_flag, connect_flag_next;
  logic          first_line, first_line_next;
  host_state_t   host_state, host_state_next;
  logic [7:0]    host_count, host_count_next;
  logic [16:0]   connect_port, connect_port_next;
  logic [16:0]   host_port, host_port_next;
  colon_state_t  colon_seen, colon_seen_next;

  // output register
  logic    out_valid;
  result_t out_data;

  logic       in_fire;
  logic [7:0] b;
  logic       res_valid;
  result_t    res;
  port_upd_t  pu;
  logic [16:0] chosen_port;

  assign b       = header.payload;
  assign in_fire = header.valid && header.ready;

  assign header.ready   = !out_valid || result.ready;
  assign result.valid   = out_valid;
  assign result.payload = out_data;

  // per-byte state update and result
  always_comb begin
    line_offset_next     = line_offset;
    line_class_next      = line_class;
    end_match_count_next = end_match_count;
    prefix_ok_next       = prefix_ok;
    connect_flag_next    = connect_flag;
    first_line_next      = first_line;
    host_state_next      = host_state;
    host_count_next      = host_count;
    connect_port_next    = connect_port;
    host_port_next       = host_port;
    colon_seen_next      = colon_seen;
    res_valid            = 1'b0;
    res                  = '0;
    pu                   = '0;
    chosen_port          = '0;

    // CONNECT check over the first seven bytes of the header
    if (first_line && line_offset < LW'(7) && b != connect_char(line_offset[2:0])) begin
      connect_flag_next = 1'b0;
    end

    if (b == CH_LF) begin
      if (host_state == HS_EMIT) begin
        host_state_next = HS_DONE;
      end
      line_offset_next = '0;
      line_class_next  = LC_UNDECIDED;
      prefix_ok_next   = 1'b1;
      colon_seen_next  = CS_WAIT;
      first_line_next  = 1'b0;
    end else begin
      if (line_offset == '0) begin
        // classify the line by its first byte
        prefix_ok_next = 1'b1;
        if (host_state != HS_NONE) begin
          line_class_next = LC_OTHER;
        end else if (b == CH_UC_C && connect_port == PORT_UNSEEN) begin
          line_class_next = LC_CONNECT;
        end else if (b == CH_UC_H) begin
          line_class_next = LC_HOST;
        end else begin
          line_class_next = LC_OTHER;
        end
      end else if (line_class == LC_CONNECT && prefix_ok) begin
        // CONNECT line: prefix, then port text
        if (line_offset < LW'(8)) begin
          if (b != connect_char(line_offset[2:0])) begin
            prefix_ok_next = 1'b0;
          end else if (line_offset == LW'(7)) begin
            connect_port_next = PORT_NONE;
          end
        end else begin
          pu                = port_step(colon_seen, connect_port, b);
          colon_seen_next   = pu.colon;
          connect_port_next = pu.port;
        end
      end else if (line_class == LC_HOST && prefix_ok) begin
        // Host line: prefix, then name bytes and port text
        if (line_offset < LW'(6)) begin
          if (b != host_char(line_offset[2:0])) begin
            prefix_ok_next = 1'b0;
          end else if (line_offset == LW'(5)) begin
            host_state_next = HS_EMIT;
          end
        end else begin
          if (host_state == HS_EMIT) begin
            if (b == CH_SPACE || b == CH_CR || b == CH_NUL || b == CH_COLON) begin
              host_state_next = HS_DONE;
            end else if (host_count < 8'(MAX_HOST)) begin
              res_valid         = 1'b1;
              res.result_kind   = RK_HOST_BYTE;
              res.host_byte     = b;
              host_count_next   = host_count + 8'd1;
            end else begin
              host_state_next = HS_TRUNC;
            end
          end
          pu              = port_step(colon_seen, host_port, b);
          colon_seen_next = pu.colon;
          host_port_next  = pu.port;
        end
      end
      if (line_offset < LW'(MAX_LINE - 1)) begin
        line_offset_next = line_offset + LW'(1);
      end
    end

    // CR LF CR LF tracking
    if (!end_match_count[0]) begin
      end_match_count_next = (b == CH_CR) ? end_match_count + 2'd1 : 2'd0;
    end else if (b == CH_LF) begin
      end_match_count_next = end_match_count + 2'd1;
    end else begin
      end_match_count_next = (b == CH_CR) ? 2'd1 : 2'd0;
    end

    // header end: summary, then clear the request
    if (end_match_count == 2'd3 && b == CH_LF) begin
      if (connect_port_next <= PORT_MAX) begin
        chosen_port = connect_port_next;
      end else if (host_port_next <= PORT_MAX) begin
        chosen_port = host_port_next;
      end else begin
        chosen_port = {1'b0, default_port};
      end
      res_valid          = 1'b1;
      res                = '0;
      res.result_kind    = RK_SUMMARY;
      res.is_connect     = connect_flag_next;
      res.host_found     = (host_state_next != HS_NONE);
      res.server_port    = chosen_port[15:0];
      res.host_length    = host_count_next;
      res.host_truncated = (host_state_next == HS_TRUNC);

      line_offset_next     = '0;
      line_class_next      = LC_UNDECIDED;
      end_match_count_next = 2'd0;
      prefix_ok_next       = 1'b1;
      connect_flag_next    = 1'b1;
      first_line_next      = 1'b1;
      host_state_next      = HS_NONE;
      host_count_next      = '0;
      connect_port_next    = PORT_UNSEEN;
      host_port_next       = PORT_NONE;
      colon_seen_next      = CS_WAIT;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_port <= DEFAULT_PORT_RST;
    end else if (cfg_wr_en) begin
      default_port <= cfg_wr_data;
    end
  end

  // request state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset     <= '0;
      line_class      <= LC_UNDECIDED;
      end_match_count <= 2'd0;
      prefix_ok       <= 1'b1;
      connect_flag    <= 1'b1;
      first_line      <= 1'b1;
      host_state      <= HS_NONE;
      host_count      <= '0;
      connect_port    <= PORT_UNSEEN;
      host_port       <= PORT_NONE;
      colon_seen      <= CS_WAIT;
    end else if (in_fire) begin
      line_offset     <= line_offset_next;
      line_class      <= line_class_next;
      end_match_count <= end_match_count_next;
      prefix_ok       <= prefix_ok_next;
      connect_flag    <= connect_flag_next;
      first_line      <= first_line_next;
      host_state      <= host_state_next;
      host_count      <= host_count_next;
      connect_port    <= connect_port_next;
      host_port       <= host_port_next;
      colon_seen      <= colon_seen_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_data <= res;
    end
  end

  // checks
  `CHP_ASSERT_ALWAYS(a_count_limit, host_count <= 8'(MAX_HOST), "host count above limit")
  `CHP_ASSERT_SAME(a_count_needs_host,
    host_state == HS_NONE, host_count == 8'd0,
    "count without host line")
  `CHP_ASSERT_SAME(a_trunc_has_host,
    out_valid && out_data.result_kind == RK_SUMMARY && out_data.host_truncated,
    out_data.host_found,
    "truncated without host")
  `CHP_ASSERT_NEXT(a_clear_after_end,
    in_fire && end_match_count == 2'd3 && b == CH_LF,
    line_offset == '0 && host_count == 8'd0 && host_state == HS_NONE && out_valid,
    "request not cleared at header end")

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import chp_pkg::*;

  localparam logic [63:0] CONNECT_WORD = "CONNECT ";
  localparam logic [47:0] HOST_WORD    = "Host: ";
  localparam logic [7:0]  CH_FF        = 8'hFF;
  localparam int          RANDOM_BYTES = 150;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  chp_stream_if #(.payload_t(logic [7:0])) header_ch ();
  chp_stream_if #(.payload_t(result_t))    result_ch ();

  connect_header_parser uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .header     (header_ch),
    .result     (result_ch)
  );

  // parser state mirrored in the bench
  logic [15:0]  fallback_port;
  logic [8:0]   cur_offset;
  line_class_t  cur_class;
  logic [1:0]   crlf_run;
  logic         prefix_match;
  logic         saw_connect;
  logic         in_first_line;
  host_state_t  name_state;
  logic [7:0]   name_count;
  logic [16:0]  connect_line_port;
  logic [16:0]  host_line_port;
  colon_state_t port_scan;

  // results still owed by the block, oldest first
  result_t parsed_results[$];

  int    mismatches;
  int    bytes_sent;
  int    burst_left;
  bit    gaps_on;
  string name_chars = "abcdefghijklmnopqrstuvwxyz0123456789.-";

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] connect_letter(input int idx);
    return CONNECT_WORD[8*(7-idx) +: 8];
  endfunction

  task automatic clear_request_state();
    cur_offset        = '0;
    cur_class         = LC_UNDECIDED;
    crlf_run          = '0;
    prefix_match      = 1'b1;
    saw_connect       = 1'b1;
    in_first_line     = 1'b1;
    name_state        = HS_NONE;
    name_count        = '0;
    connect_line_port = PORT_UNSEEN;
    host_line_port    = PORT_NONE;
    port_scan         = CS_WAIT;
  endtask

  // colon then leading digits, saturating
  task automatic scan_port(inout logic [16:0] port, input logic [7:0] b);
    int unsigned v;
    case (port_scan)
      CS_WAIT: begin
        if (b == CH_COLON) begin
          port_scan = CS_DIGITS;
          port = '0;
        end
      end
      CS_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          v = int'(port) * 10 + int'(b - CH_ZERO);
          port = (v > int'(PORT_MAX)) ? PORT_MAX : 17'(v);
        end else begin
          port_scan = CS_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // advance the mirrored parser by one header byte
  task automatic parse_header_byte(input logic [7:0] b);
    result_t r;
    logic [8:0] pos;
    pos = cur_offset;

    if (in_first_line && pos < 7) begin
      if (b != connect_letter(int'(pos))) saw_connect = 1'b0;
    end

    if (b == CH_LF) begin
      if (name_state == HS_EMIT) name_state = HS_DONE;
      cur_offset    = '0;
      cur_class     = LC_UNDECIDED;
      prefix_match  = 1'b1;
      port_scan     = CS_WAIT;
      in_first_line = 1'b0;
    end else begin
      if (pos == 0) begin
        // first byte picks the line class
        prefix_match = 1'b1;
        if (name_state != HS_NONE) cur_class = LC_OTHER;
        else if (b == CH_UC_C && connect_line_port == PORT_UNSEEN) cur_class = LC_CONNECT;
        else if (b == CH_UC_H) cur_class = LC_HOST;
        else cur_class = LC_OTHER;
      end else if (cur_class == LC_CONNECT && prefix_match) begin
        if (pos < 8) begin
          if (b != connect_letter(int'(pos))) prefix_match = 1'b0;
          else if (pos == 7) connect_line_port = PORT_NONE;
        end else begin
          scan_port(connect_line_port, b);
        end
      end else if (cur_class == LC_HOST && prefix_match) begin
        if (pos < 6) begin
          if (b != HOST_WORD[8*(5-int'(pos)) +: 8]) prefix_match = 1'b0;
          else if (pos == 5) name_state = HS_EMIT;
        end else begin
          // host name bytes until a stop byte or the limit
          if (name_state == HS_EMIT) begin
            if (b == CH_SPACE || b == CH_CR || b == CH_NUL || b == CH_COLON) begin
              name_state = HS_DONE;
            end else if (name_count < MAX_HOST) begin
              r = '0;
              r.result_kind = RK_HOST_BYTE;
              r.host_byte = b;
              parsed_results.push_back(r);
              name_count++;
            end else begin
              name_state = HS_TRUNC;
            end
          end
          scan_port(host_line_port, b);
        end
      end
      if (cur_offset < MAX_LINE_DEF - 1) cur_offset++;
    end

    // header end detection on cr lf cr lf
    if (!crlf_run[0]) begin
      crlf_run = (b == CH_CR) ? crlf_run + 2'd1 : 2'd0;
    end else if (b == CH_LF) begin
      if (crlf_run == 2'd3) begin
        r = '0;
        r.result_kind = RK_SUMMARY;
        r.is_connect = saw_connect;
        r.host_found = (name_state != HS_NONE);
        if (connect_line_port <= PORT_MAX) r.server_port = connect_line_port[15:0];
        else if (host_line_port <= PORT_MAX) r.server_port = host_line_port[15:0];
        else r.server_port = fallback_port;
        r.host_length = name_count;
        r.host_truncated = (name_state == HS_TRUNC);
        parsed_results.push_back(r);
        clear_request_state();
        return;
      end
      crlf_run = crlf_run + 2'd1;
    end else begin
      crlf_run = (b == CH_CR) ? 2'd1 : 2'd0;
    end
  endtask

  // one header byte, with bursts and gaps on the sending side
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
        repeat (gap) begin
          @(negedge clk);
          header_ch.valid <= 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    header_ch.valid   <= 1'b1;
    header_ch.payload <= b;
    do @(posedge clk); while (!header_ch.ready);
    bytes_sent++;
    parse_header_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_crlf();
  endtask

  // text with one byte replaced at random
  task automatic send_mangled(input string s);
    int p;
    p = $urandom_range(0, s.len() - 1);
    for (int i = 0; i < s.len(); i++) begin
      if (i == p) send_byte(8'($urandom_range(0, 255)));
      else send_byte(s[i]);
    end
  endtask

  task automatic send_name(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(name_chars[$urandom_range(0, name_chars.len() - 1)]);
    end
  endtask

  // colon, zero or more digits, sometimes enough to saturate
  task automatic send_port_text();
    int ndig;
    ndig = $urandom_range(0, 7);
    send_byte(CH_COLON);
    repeat (ndig) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic set_default_port(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    fallback_port = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // stop sending and let every owed result come out
  task automatic wait_drained();
    @(negedge clk);
    header_ch.valid <= 1'b0;
    while (parsed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    $display("%0t mismatch %s expected %0d actual %0d", $time, what, want, got);
  endtask

  // result checker
  initial begin
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (parsed_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result transaction expected none actual %h", $time, got);
        end else begin
          want = parsed_results.pop_front();
          if (got.result_kind !== want.result_kind)
            note_mismatch("result_kind", want.result_kind, got.result_kind);
          if (got.host_byte !== want.host_byte)
            note_mismatch("host_byte", want.host_byte, got.host_byte);
          if (got.is_connect !== want.is_connect)
            note_mismatch("is_connect", want.is_connect, got.is_connect);
          if (got.host_found !== want.host_found)
            note_mismatch("host_found", want.host_found, got.host_found);
          if (got.server_port !== want.server_port)
            note_mismatch("server_port", want.server_port, got.server_port);
          if (got.host_length !== want.host_length)
            note_mismatch("host_length", want.host_length, got.host_length);
          if (got.host_truncated !== want.host_truncated)
            note_mismatch("host_truncated", want.host_truncated, got.host_truncated);
        end
      end
    end
  end

  // receiver back-pressure, switching between a few patterns
  initial begin
    int mode;
    int span;
    int stall;
    int phase;
    result_ch.ready = 1'b0;
    stall = 0;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk);
        phase++;
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: begin
            if (stall > 0) begin
              stall--;
              result_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 29) == 0) begin
              stall = $urandom_range(8, 20);
              result_ch.ready <= 1'b0;
            end else begin
              result_ch.ready <= 1'b1;
            end
          end
          default: result_ch.ready <= (phase % 4 == 0);
        endcase
      end
    end
  end

  // reset value of the default port
  task automatic test_reset_default();
    send_line("CONNECT example.org HTTP/1.1");
    send_line("Host: example.org");
    send_crlf();
    wait_drained();
  endtask

  // connect line port, host line port, empty port, saturation, default
  task automatic test_port_choice();
    set_default_port(16'd0);
    send_line("CONNECT a.b:443 HTTP/1.1");
    send_line("Host: a.b:8080");
    send_crlf();
    send_line("GET / HTTP/1.1");
    send_line("Host: web:8080");
    send_crlf();
    send_line("CONNECT a: HTTP/1.1");
    send_crlf();
    send_line("CONNECT a:9999999");
    send_line("Host: z:12");
    send_crlf();
    send_line("GET /");
    send_line("Host: q");
    send_crlf();
    wait_drained();
  endtask

  // host name stop bytes, extreme byte values, missing host line
  task automatic test_name_ends();
    set_default_port(16'hFFFF);
    send_line("Host: ab cd");
    send_crlf();
    send_text("Host: ab");
    send_byte(CH_NUL);
    send_line("cd");
    send_crlf();
    send_text("Host: x");
    send_byte(CH_FF);
    send_line("y");
    send_crlf();
    // name ended by a bare line feed
    send_text("Host: xy");
    send_byte(CH_LF);
    send_crlf();
    send_crlf();
    send_line("CONNECT");
    send_crlf();
    send_crlf();
    send_crlf();
    wait_drained();
  endtask

  // names at and past the host limit, line longer than the line limit
  task automatic test_long_name();
    set_default_port(16'd443);
    send_text("Host: ");
    repeat (MAX_HOST) send_byte("h");
    send_crlf();
    send_crlf();
    send_line("CONNECT far");
    send_text("Host: ");
    repeat (510) send_byte("n");
    send_line(":77");
    send_crlf();
    wait_drained();
  endtask

  // broken prefixes, later lines, odd end sequences
  task automatic test_prefixes();
    set_default_port(16'($urandom_range(1, 65534)));
    send_line("CONNECX a:1");
    send_line("Host: h");
    send_crlf();
    send_line("xCONNECT a:5");
    send_line("CONNECT b:6 ");
    send_crlf();
    send_line("Hostx: a");
    send_line("host: b");
    send_line("Host: c");
    send_line("Host: d:9");
    send_crlf();
    send_text("Host: e");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_crlf();
    wait_drained();
  endtask

  // one request: mostly well formed, some noise and broken lines
  task automatic send_random_request();
    int kind;
    int nlines;
    int host_at;
    int name_len;
    bit bare_lf;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 40)) begin
        if ($urandom_range(0, 5) == 0) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        else send_byte(8'($urandom_range(0, 255)));
      end
      send_crlf();
      send_crlf();
      return;
    end

    // request line
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      send_text("CONNECT ");
      send_name($urandom_range(1, 12));
      if ($urandom_range(0, 3) != 0) send_port_text();
      if ($urandom_range(0, 1) == 1) send_text(" HTTP/1.1");
    end else if (kind < 8) begin
      send_text("GET / HTTP/1.1");
    end else begin
      send_mangled("CONNECT ");
      send_name($urandom_range(1, 8));
      send_port_text();
    end
    bare_lf = ($urandom_range(0, 9) == 0);
    if (bare_lf) send_byte(CH_LF);
    else send_crlf();

    // header lines, usually one host line among them
    nlines = $urandom_range(0, 4);
    host_at = $urandom_range(0, nlines);
    for (int i = 0; i <= nlines; i++) begin
      if (i == host_at && $urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 5) == 0) send_mangled("Host: ");
        else send_text("Host: ");
        name_len = ($urandom_range(0, 99) < 4) ? $urandom_range(145, 160)
                                                : $urandom_range(0, 16);
        send_name(name_len);
        if ($urandom_range(0, 2) == 0) send_port_text();
        if ($urandom_range(0, 4) == 0) send_text(" x");
      end else begin
        case ($urandom_range(0, 3))
          0: send_text("Accept: */*");
          1: begin
            send_text("CONNECT y");
            send_port_text();
          end
          2: send_text("Hos");
          default: begin
            send_text("X-Tag: ");
            send_name($urandom_range(0, 10));
          end
        endcase
      end
      bare_lf = ($urandom_range(0, 9) == 0);
      if (bare_lf) send_byte(CH_LF);
      else send_crlf();
    end
    // the blank line needs a cr lf in front of it
    if (bare_lf) send_crlf();
    send_crlf();
  endtask

  // random requests in phases with different default ports
  task automatic test_random_requests();
    int start;
    int quota;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 1) set_default_port(16'd0);
      else if (ph == 3) set_default_port(16'hFFFF);
      else set_default_port(16'($urandom_range(0, 65535)));
      // one phase without gaps on the sending side
      gaps_on = (ph != 2);
      start = bytes_sent;
      quota = RANDOM_BYTES / 5;
      while (bytes_sent - start < quota) begin
        send_random_request();
        // hold off now and then until the block has caught up
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  // main sequence
  initial begin
    int guard;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    header_ch.valid    = 1'b0;
    header_ch.payload  = '0;
    mismatches         = 0;
    bytes_sent         = 0;
    burst_left         = 0;
    gaps_on            = 1'b1;
    fallback_port      = DEFAULT_PORT_RST;
    clear_request_state();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_port_choice();
    test_name_ends();
    test_long_name();
    test_prefixes();
    test_random_requests();

    // drain with a limit, then check that nothing is still owed
    @(negedge clk);
    header_ch.valid <= 1'b0;
    guard = 0;
    while (parsed_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (parsed_results.size() != 0) begin
      mismatches++;
      $display("%0t %0d expected results never arrived", $time, parsed_results.size());
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
